// ----- rtl/core/aptb_pkg.sv -----
// types, constants and helper functions for the arc and pie to bezier block
`timescale 1ns / 1ps

package aptb_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CSTEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam int ZW = 32;   // cordic angle, degree * 2^22
  localparam int VW = 33;   // cordic x and y, q30
  localparam int QW = 25;   // handle factor quotient bits
  localparam int KW = 25;   // signed handle factor, q16
  localparam int PW = 58;   // handle factor times sine or cosine
  localparam int TW = 42;   // bezier term, q30
  localparam int NW = 50;   // divider numerator
  localparam int DW = 35;   // divider denominator
  localparam int RW = 60;   // divider compare width

  localparam logic signed [VW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [QW-1:0] HANDLE_MAX = 25'd16711680;

  // full turn in 1/64 degree, and in units of 2^14 for the quarter sweep
  localparam logic signed [17:0] A_FULL = 18'sd23040;
  localparam logic signed [17:0] T_FULL = 18'sd92160;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_CUBIC = 2'd2;

  typedef struct packed {
    logic signed [23:0] box_x;
    logic signed [23:0] box_y;
    logic [22:0]        box_width;
    logic [22:0]        box_height;
    logic signed [15:0] start_angle;
    logic signed [15:0] sweep_angle;
    logic               mode;
  } item_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [1:0]         point_kind;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic signed [17:0] z;
    logic               neg;
  } red_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [23:0]   cx;
    logic signed [23:0]   cy;
    logic [22:0]          w;
    logic [22:0]          h;
    logic                 pie;
    logic                 swz;
    rot_t                 ra;
    rot_t                 rb;
    rot_t                 rt;
    logic                 na;
    logic                 nb;
    logic                 nt;
    logic signed [VW-1:0] sa;
    logic signed [VW-1:0] ca;
    logic signed [VW-1:0] sb;
    logic signed [VW-1:0] cb;
    logic signed [VW-1:0] ts;
    logic signed [VW-1:0] tc;
    logic [NW-1:0]        num;
    logic [DW-1:0]        den;
    logic [NW-1:0]        rem;
    logic [QW-1:0]        q;
    logic                 qneg;
    logic                 tc0;
    logic                 kmax;
    logic signed [KW-1:0] k;
    logic [3:0][PW-1:0]   kp;
    logic [7:0][TW-1:0]   term;
    logic [7:0][45:0]     plo;
    logic [7:0][44:0]     phi;
    logic [7:0][23:0]     pt;
  } pipe_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    case (i)
      5'd0:  a = 32'sd188743680;
      5'd1:  a = 32'sd111421900;
      5'd2:  a = 32'sd58872272;
      5'd3:  a = 32'sd29884485;
      5'd4:  a = 32'sd15000234;
      5'd5:  a = 32'sd7507429;
      5'd6:  a = 32'sd3754631;
      5'd7:  a = 32'sd1877430;
      5'd8:  a = 32'sd938729;
      5'd9:  a = 32'sd469366;
      5'd10: a = 32'sd234683;
      5'd11: a = 32'sd117342;
      5'd12: a = 32'sd58671;
      5'd13: a = 32'sd29335;
      5'd14: a = 32'sd14668;
      5'd15: a = 32'sd7334;
      5'd16: a = 32'sd3667;
      5'd17: a = 32'sd1833;
      5'd18: a = 32'sd917;
      5'd19: a = 32'sd458;
      5'd20: a = 32'sd229;
      5'd21: a = 32'sd115;
      5'd22: a = 32'sd57;
      5'd23: a = 32'sd29;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > 40'sd8388607) r = 24'sh7fffff;
    else if (v < -40'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // wrap into one turn, then fold into the right half plane
  function automatic red_t ang_reduce(input logic signed [17:0] v,
                                      input logic signed [17:0] full);
    red_t r;
    logic signed [17:0] z;
    z = v;
    for (int n = 0; n < 3; n++) if (z < 0) z = z + full;
    for (int n = 0; n < 3; n++) if (z >= full) z = z - full;
    if (z > (full >>> 1)) z = z - full;
    r.neg = 1'b0;
    if (z > (full >>> 2)) begin
      z = z - (full >>> 1);
      r.neg = 1'b1;
    end else if (z < -(full >>> 2)) begin
      z = z + (full >>> 1);
      r.neg = 1'b1;
    end
    r.z = z;
    return r;
  endfunction

endpackage

// ----- rtl/core/arc_pie_to_bezier.sv -----
// top level: elliptical arc or pie to one cubic bezier segment
`timescale 1ns / 1ps

// arc and pie to cubic bezier converter
//
// item channel (item_valid, item_stall, item) takes one request: an ellipse
// box, a start and a sweep angle and a mode. the point channel (point_valid,
// point_stall, point) returns its points in order: arc mode gives the start
// point and three bezier points (4 points), pie mode gives the centre, a line
// to the arc start, three bezier points and a line back to the centre
// (6 points). last_point marks the final point of each request.
//
// the datapath is a pipeline of CSTEPS + 34 register stages (50 at 16 steps):
// entry and angle wrap, one cordic rotation per stage for three angles at
// once, sign fix, divider setup, one quotient bit per stage for the handle
// factor, then multiply and coordinate stages.
// throughput is set by the output register, which sends one point per cycle
// while the receiver does not stall; the pipeline moves as a whole and
// freezes while that register still has points left.
// when the receiver stalls, the current point holds and the pipeline and
// item_stall hold with it, so no request is lost or repeated.
// reset clears all valid bits; nothing else needs clearing.
module arc_pie_to_bezier (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  aptb_pkg::item_t item,
  output logic            point_valid,
  input  logic            point_stall,
  output aptb_pkg::point_t point
);
  import aptb_pkg::*;

  // stage indexes
  localparam int LC     = CSTEPS;
  localparam int S_NEG  = LC + 1;
  localparam int S_DIV0 = LC + 2;
  localparam int S_OVF  = LC + 3;
  localparam int S_K    = S_OVF + QW + 1;
  localparam int S_MUL  = S_K + 1;
  localparam int S_TERM = S_MUL + 1;
  localparam int S_PART = S_TERM + 1;
  localparam int S_SUM  = S_PART + 1;
  localparam int LAST   = S_SUM;

  pipe_t pipe [0:LAST];
  pipe_t nxt  [0:LAST];
  logic  vld  [0:LAST];

  // output hold register
  pipe_t      hold;
  logic       hv;
  logic [2:0] idx;
  logic [2:0] pos;
  logic       last;
  logic       en;

  // centre: (2x + w) / 512 truncated toward zero, back to q8
  function automatic logic signed [23:0] centre(input logic signed [23:0] x,
                                                input logic [22:0] w);
    logic signed [25:0] cs;
    logic signed [16:0] q;
    cs = (26'(x) <<< 1) + $signed(26'(w));
    q = 17'(cs >>> 9);
    if (cs < 0 && cs[8:0] != 9'd0) q = q + 17'sd1;
    return sat24(40'(q) <<< 8);
  endfunction

  function automatic pipe_t f_entry(input item_t it);
    pipe_t p;
    red_t ra;
    red_t rb;
    red_t rt;
    logic signed [17:0] sab;
    p = '0;
    sab = 18'(it.start_angle) + 18'(it.sweep_angle);
    ra = ang_reduce(18'(it.start_angle), A_FULL);
    rb = ang_reduce(sab, A_FULL);
    rt = ang_reduce(18'(it.sweep_angle), T_FULL);
    p.ra.z = ZW'(ra.z) <<< 16;
    p.rb.z = ZW'(rb.z) <<< 16;
    p.rt.z = ZW'(rt.z) <<< 14;
    p.ra.x = CORDIC_GAIN;
    p.rb.x = CORDIC_GAIN;
    p.rt.x = CORDIC_GAIN;
    p.ra.y = '0;
    p.rb.y = '0;
    p.rt.y = '0;
    p.na = ra.neg;
    p.nb = rb.neg;
    p.nt = rt.neg;
    p.cx = centre(it.box_x, it.box_width);
    p.cy = centre(it.box_y, it.box_height);
    p.w = it.box_width;
    p.h = it.box_height;
    p.pie = it.mode;
    p.swz = (it.sweep_angle == 16'sd0);
    return p;
  endfunction

  function automatic rot_t cordic_rot(input rot_t r, input int i);
    rot_t n;
    if (r.z >= 0) begin
      n.x = r.x - (r.y >>> i);
      n.y = r.y + (r.x >>> i);
      n.z = r.z - atan_tab(5'(i));
    end else begin
      n.x = r.x + (r.y >>> i);
      n.y = r.y - (r.x >>> i);
      n.z = r.z + atan_tab(5'(i));
    end
    return n;
  endfunction

  function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
    return (v < 0) ? VW'(-v) : VW'(v);
  endfunction

  function automatic pipe_t f_div0(input pipe_t pin);
    pipe_t p;
    logic [DW-1:0] ac;
    p = pin;
    ac = DW'(mag(p.tc));
    p.num = NW'(mag(p.ts)) << 18;
    p.den = ac + (ac << 1);
    p.qneg = p.ts[VW-1] ^ p.tc[VW-1];
    p.tc0 = (p.tc == '0);
    return p;
  endfunction

  function automatic pipe_t f_div_step(input pipe_t pin, input int s);
    pipe_t p;
    logic [RW-1:0] dsh;
    p = pin;
    dsh = RW'(p.den) << (QW - 1 - s);
    if (RW'(p.rem) >= dsh) begin
      p.rem = NW'(RW'(p.rem) - dsh);
      p.q[5'(QW - 1 - s)] = 1'b1;
    end
    return p;
  endfunction

  function automatic pipe_t f_k(input pipe_t pin);
    pipe_t p;
    logic [QW-1:0] m;
    p = pin;
    m = (p.kmax || p.q > HANDLE_MAX) ? HANDLE_MAX : p.q;
    if (p.swz) p.k = '0;
    else if (p.qneg) p.k = -$signed(m);
    else p.k = $signed(m);
    return p;
  endfunction

  function automatic pipe_t f_mul(input pipe_t pin);
    pipe_t p;
    logic signed [PW-1:0] m0;
    logic signed [PW-1:0] m1;
    logic signed [PW-1:0] m2;
    logic signed [PW-1:0] m3;
    p = pin;
    m0 = p.k * p.sa;
    m1 = p.k * p.ca;
    m2 = p.k * p.sb;
    m3 = p.k * p.cb;
    p.kp[0] = m0;
    p.kp[1] = m1;
    p.kp[2] = m2;
    p.kp[3] = m3;
    return p;
  endfunction

  function automatic pipe_t f_term(input pipe_t pin);
    pipe_t p;
    p = pin;
    p.term[0] = TW'(p.ca);
    p.term[1] = TW'(p.sa);
    p.term[2] = TW'(p.ca) - TW'($signed(p.kp[0]) >>> 16);
    p.term[3] = TW'(p.sa) + TW'($signed(p.kp[1]) >>> 16);
    p.term[4] = TW'(p.cb) + TW'($signed(p.kp[2]) >>> 16);
    p.term[5] = TW'(p.sb) - TW'($signed(p.kp[3]) >>> 16);
    p.term[6] = TW'(p.cb);
    p.term[7] = TW'(p.sb);
    return p;
  endfunction

  // radius times term split into two partial products
  function automatic pipe_t f_part(input pipe_t pin);
    pipe_t p;
    logic signed [23:0] rad;
    logic signed [20:0] th;
    logic signed [21:0] tl;
    logic signed [45:0] lo;
    logic signed [44:0] hi;
    p = pin;
    for (int j = 0; j < 8; j++) begin
      rad = (j % 2 == 0) ? $signed({1'b0, p.w}) : $signed({1'b0, p.h});
      th = $signed(p.term[j][TW-1:21]);
      tl = $signed({1'b0, p.term[j][20:0]});
      hi = rad * th;
      lo = rad * tl;
      p.phi[j] = hi;
      p.plo[j] = lo;
    end
    return p;
  endfunction

  // round half up from q39 to q8, add the centre, saturate
  function automatic pipe_t f_sum(input pipe_t pin);
    pipe_t p;
    logic signed [65:0] full;
    logic signed [65:0] rs;
    logic signed [23:0] cen;
    p = pin;
    for (int j = 0; j < 8; j++) begin
      cen = (j % 2 == 0) ? p.cx : p.cy;
      full = (66'($signed(p.phi[j])) <<< 21) + 66'($signed(p.plo[j])) + (66'sd1 <<< 30);
      rs = full >>> 31;
      p.pt[j] = sat24(40'(rs) + 40'(cen));
    end
    return p;
  endfunction

  always_comb begin
    nxt[0] = f_entry(item);
    for (int i = 1; i <= LC; i++) begin
      nxt[i] = pipe[i-1];
      nxt[i].ra = cordic_rot(pipe[i-1].ra, i - 1);
      nxt[i].rb = cordic_rot(pipe[i-1].rb, i - 1);
      nxt[i].rt = cordic_rot(pipe[i-1].rt, i - 1);
    end
    // undo the half turn fold
    nxt[S_NEG] = pipe[S_NEG-1];
    nxt[S_NEG].sa = pipe[S_NEG-1].na ? -pipe[S_NEG-1].ra.y : pipe[S_NEG-1].ra.y;
    nxt[S_NEG].ca = pipe[S_NEG-1].na ? -pipe[S_NEG-1].ra.x : pipe[S_NEG-1].ra.x;
    nxt[S_NEG].sb = pipe[S_NEG-1].nb ? -pipe[S_NEG-1].rb.y : pipe[S_NEG-1].rb.y;
    nxt[S_NEG].cb = pipe[S_NEG-1].nb ? -pipe[S_NEG-1].rb.x : pipe[S_NEG-1].rb.x;
    nxt[S_NEG].ts = pipe[S_NEG-1].nt ? -pipe[S_NEG-1].rt.y : pipe[S_NEG-1].rt.y;
    nxt[S_NEG].tc = pipe[S_NEG-1].nt ? -pipe[S_NEG-1].rt.x : pipe[S_NEG-1].rt.x;
    nxt[S_DIV0] = f_div0(pipe[S_DIV0-1]);
    // quotient too wide for the QW quotient bits, or zero cosine
    nxt[S_OVF] = pipe[S_OVF-1];
    nxt[S_OVF].kmax = pipe[S_OVF-1].tc0 ||
                      (RW'(pipe[S_OVF-1].num) >= (RW'(pipe[S_OVF-1].den) << QW));
    nxt[S_OVF].rem = pipe[S_OVF-1].num;
    nxt[S_OVF].q = '0;
    for (int s = 0; s < QW; s++) begin
      nxt[S_OVF+1+s] = f_div_step(pipe[S_OVF+s], s);
    end
    nxt[S_K]    = f_k(pipe[S_K-1]);
    nxt[S_MUL]  = f_mul(pipe[S_MUL-1]);
    nxt[S_TERM] = f_term(pipe[S_TERM-1]);
    nxt[S_PART] = f_part(pipe[S_PART-1]);
    nxt[S_SUM]  = f_sum(pipe[S_SUM-1]);
  end

  // point order inside one request
  assign pos  = hold.pie ? idx : idx + 3'd1;
  assign last = hold.pie ? (idx == 3'd5) : (idx == 3'd3);

  // pipeline moves when the hold register is free or gives its last point
  assign en          = !hv || (!point_stall && last);
  assign item_stall  = !en;
  assign point_valid = hv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) vld[i] <= 1'b0;
      hv  <= 1'b0;
      idx <= 3'd0;
    end else if (en) begin
      vld[0] <= item_valid;
      for (int i = 1; i <= LAST; i++) vld[i] <= vld[i-1];
      hv  <= vld[LAST];
      idx <= 3'd0;
    end else if (hv && !point_stall) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= LAST; i++) pipe[i] <= nxt[i];
      hold <= pipe[LAST];
    end
  end

  always_comb begin
    point.last_point = last;
    case (pos)
      3'd0: begin
        point.point_x    = hold.cx;
        point.point_y    = hold.cy;
        point.point_kind = KIND_START;
      end
      3'd1: begin
        point.point_x    = hold.pt[0];
        point.point_y    = hold.pt[1];
        point.point_kind = hold.pie ? KIND_LINE : KIND_START;
      end
      3'd2: begin
        point.point_x    = hold.pt[2];
        point.point_y    = hold.pt[3];
        point.point_kind = KIND_CUBIC;
      end
      3'd3: begin
        point.point_x    = hold.pt[4];
        point.point_y    = hold.pt[5];
        point.point_kind = KIND_CUBIC;
      end
      3'd4: begin
        point.point_x    = hold.pt[6];
        point.point_y    = hold.pt[7];
        point.point_kind = KIND_CUBIC;
      end
      default: begin
        point.point_x    = hold.cx;
        point.point_y    = hold.cy;
        point.point_kind = KIND_LINE;
      end
    endcase
  end

endmodule

// ----- sim/arc_pie_to_bezier_chk.sv -----
// point stream checker for the arc and pie to bezier block
`timescale 1ns / 1ps

module arc_pie_to_bezier_chk (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  aptb_pkg::item_t  item,
  input  logic             point_valid,
  input  logic             point_stall,
  input  aptb_pkg::point_t point,
  output int               errors,
  output int               pending
);
  import aptb_pkg::*;

  localparam longint TURN = 1509949440;
  localparam longint HALF_TURN = 754974720;
  localparam longint QTR_TURN = 377487360;
  localparam longint GAIN = 652032874;
  localparam longint KLIMIT = 255 * 65536;

  point_t expected_points[$];
  longint rot_angle[24] = '{188743680, 111421900, 58872272, 29884485, 15000234,
    7507429, 3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  // floor shift for signed values
  function automatic longint floor_shr(longint v, int k);
    if (v >= 0) return v >>> k;
    return -(((-v) - 1) >>> k) - 1;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic sin_cos(input longint a, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    int steps;
    x = GAIN; y = 0; flip = 0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    z = ((a % TURN) + TURN) % TURN;
    if (z > HALF_TURN) z -= TURN;
    if (z > QTR_TURN) begin
      z -= HALF_TURN; flip = 1;
    end else if (z < -QTR_TURN) begin
      z += HALF_TURN; flip = 1;
    end
    for (int i = 0; i < steps; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i); y = y + floor_shr(x, i); z -= rot_angle[i];
      end else begin
        nx = x + floor_shr(y, i); y = y - floor_shr(x, i); z += rot_angle[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint place(longint ctr, longint rad, longint term);
    return clamp24(ctr + floor_shr(rad * term + (64'sd1 <<< 30), 31));
  endfunction

  function automatic point_t mk(longint x, longint y, logic [1:0] kind);
    point_t p;
    p.point_x = x[23:0]; p.point_y = y[23:0];
    p.point_kind = kind; p.last_point = 1'b0;
    return p;
  endfunction

  task automatic predict_points(input item_t it);
    longint x, y, w, h, st, sw, cx, cy, sa, ca, sb, cb, k, ts, tc;
    point_t pts[$];
    x = it.box_x; y = it.box_y; w = it.box_width; h = it.box_height;
    st = it.start_angle; sw = it.sweep_angle;
    cx = clamp24(((2 * x + w) / 512) * 256);
    cy = clamp24(((2 * y + h) / 512) * 256);
    sin_cos(st * 65536, sa, ca);
    sin_cos((st + sw) * 65536, sb, cb);
    if (sw == 0) k = 0;
    else begin
      sin_cos(sw * 16384, ts, tc);
      if (tc == 0) k = (ts >= 0) ? KLIMIT : -KLIMIT;
      else k = (ts * 4 * 65536) / (3 * tc);
      if (k > KLIMIT) k = KLIMIT;
      if (k < -KLIMIT) k = -KLIMIT;
    end
    if (it.mode) begin
      pts.push_back(mk(cx, cy, KIND_START));
      pts.push_back(mk(place(cx, w, ca), place(cy, h, sa), KIND_LINE));
    end else
      pts.push_back(mk(place(cx, w, ca), place(cy, h, sa), KIND_START));
    pts.push_back(mk(place(cx, w, ca - floor_shr(k * sa, 16)),
                     place(cy, h, sa + floor_shr(k * ca, 16)), KIND_CUBIC));
    pts.push_back(mk(place(cx, w, cb + floor_shr(k * sb, 16)),
                     place(cy, h, sb - floor_shr(k * cb, 16)), KIND_CUBIC));
    pts.push_back(mk(place(cx, w, cb), place(cy, h, sb), KIND_CUBIC));
    if (it.mode) pts.push_back(mk(cx, cy, KIND_LINE));
    pts[pts.size() - 1].last_point = 1'b1;
    foreach (pts[i]) expected_points.push_back(pts[i]);
  endtask

  task automatic report(input string what, input point_t got, input point_t want);
    $display("mismatch %s: got x=%0d y=%0d kind=%0d last=%0d, want x=%0d y=%0d kind=%0d last=%0d",
             what, got.point_x, got.point_y, got.point_kind, got.last_point,
             want.point_x, want.point_y, want.point_kind, want.last_point);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst) begin
      if (item_valid && !item_stall) predict_points(item);
      if (point_valid && !point_stall) begin
        if (expected_points.size() == 0) report("unexpected point", point, '0);
        else begin
          want = expected_points.pop_front();
          if (point.point_x !== want.point_x) report("point_x", point, want);
          else if (point.point_y !== want.point_y) report("point_y", point, want);
          else if (point.point_kind !== want.point_kind) report("point_kind", point, want);
          else if (point.last_point !== want.last_point) report("last_point", point, want);
        end
      end
    end
    pending = expected_points.size();
  end
endmodule

// ----- sim/arc_pie_to_bezier_tb.sv -----
// testbench top: stimulus, stalls and verdict for the arc and pie to bezier block
`timescale 1ns / 1ps

module arc_pie_to_bezier_tb;
  import aptb_pkg::*;

  localparam int RANDOM_REQUESTS = 260;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   item_valid = 1'b0;
  logic   item_stall;
  item_t  item = '0;
  logic   point_valid;
  logic   point_stall = 1'b0;
  point_t point;
  int     errors, pending;
  int     cycles = 0;
  bit     hold_off = 1'b0;   // long receiver stall to back up the pipeline

  arc_pie_to_bezier dut (.clk(clk), .rst(rst), .item_valid(item_valid),
    .item_stall(item_stall), .item(item), .point_valid(point_valid),
    .point_stall(point_stall), .point(point));

  arc_pie_to_bezier_chk chk (.clk(clk), .rst(rst), .item_valid(item_valid),
    .item_stall(item_stall), .item(item), .point_valid(point_valid),
    .point_stall(point_stall), .point(point), .errors(errors), .pending(pending));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(0, 3);
  endfunction

  // receiver stall pattern, with calm stretches and one long hold-off
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        point_stall <= 1'b1;
        for (n = 0; n < 400; n++) @(negedge clk);
        hold_off = 1'b0;
      end
      n = gap_len();
      point_stall <= (n != 0);
      repeat (n == 0 ? $urandom_range(1, 30) : n) @(negedge clk);
    end
  end

  // offer one request and wait for it to be taken
  task automatic send(input item_t it);
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      item_valid <= 1'b0;
      item <= '0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic item_t make_item(int sx, int sy, int w, int h, int st, int sw,
                                      bit pie);
    item_t it;
    it.box_x = 24'(sx); it.box_y = 24'(sy);
    it.box_width = 23'(w); it.box_height = 23'(h);
    it.start_angle = 16'(st); it.sweep_angle = 16'(sw); it.mode = pie;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    r = $urandom_range(0, 9);
    it.box_x = 24'($urandom); it.box_y = 24'($urandom);
    it.box_width = 23'($urandom); it.box_height = 23'($urandom);
    it.start_angle = 16'($urandom); it.sweep_angle = 16'($urandom);
    it.mode = 1'($urandom);
    if (r < 6) begin
      // everyday angles within one turn, and for half of them moderate boxes
      it.start_angle = 16'($signed($urandom_range(0, 46080)) - 23040);
      it.sweep_angle = 16'($signed($urandom_range(0, 46080)) - 23040);
      if (r < 3) begin
        it.box_x = 24'($signed($urandom_range(0, 200000)) - 100000);
        it.box_y = 24'($signed($urandom_range(0, 200000)) - 100000);
        it.box_width = 23'($urandom_range(0, 100000));
        it.box_height = 23'($urandom_range(0, 100000));
      end
    end else if (r == 6) begin
      // quarter-turn multiples hit exact zero cosines
      it.start_angle = 16'($signed($urandom_range(0, 8)) * 5760 - 23040);
      it.sweep_angle = 16'($signed($urandom_range(0, 8)) * 5760 - 23040);
    end
    return it;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes of the fields, both modes, zero sweep, handle saturation
    send(make_item(0, 0, 0, 0, 0, 0, 0));
    send(make_item(0, 0, 0, 0, 0, 0, 1));
    send(make_item(2560, 2560, 25600, 12800, 0, 5760, 0));
    send(make_item(2560, 2560, 25600, 12800, 5760, 5760, 1));
    send(make_item(-8388608, -8388608, 0, 0, 0, 0, 1));
    send(make_item(8388607, 8388607, 8388607, 8388607, 0, 23040, 1));
    send(make_item(-8388608, 8388607, 8388607, 0, -23040, -23040, 0));
    send(make_item(8388607, -8388608, 0, 8388607, 23040, 23040, 1));
    send(make_item(0, 0, 8388607, 8388607, 1000, 23040, 0));
    send(make_item(0, 0, 8388607, 8388607, 1000, -23040, 1));
    send(make_item(-1, -1, 1, 1, 1, 1, 0));
    send(make_item(-300, 500, 511, 513, -1, -1, 1));
    send(make_item(1000, -1000, 40000, 30000, 32767, 32767, 0));
    send(make_item(1000, -1000, 40000, 30000, -32768, -32768, 1));
    send(make_item(1000, -1000, 40000, 30000, 11520, 11520, 0));
    send(make_item(1000, -1000, 40000, 30000, -11520, -17280, 1));
    send(make_item(5000, 5000, 12345, 54321, 17280, 2880, 0));
    send(make_item(5000, 5000, 12345, 54321, 90, -64, 1));
    send(make_item(0, 0, 8388607, 8388607, 23040, 0, 0));
    send(make_item(-4194304, 4194304, 4194303, 4194303, 0, 22000, 1));

    // fill the pipeline against a long receiver hold-off
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) send(random_item());

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      send(random_item());
      idle_gap(gap_len());
    end
    item_valid <= 1'b0;
    item <= '0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
